// ===== hw/rtl/potc_pkg.sv =====
// Shared types and constants for the priority-ordered chain table.
package potc_pkg;

  localparam int ID_BITS           = 8;
  localparam int PRI_BITS          = 8;
  localparam int CMD_W             = 2;
  localparam int HOOK_W            = 3;
  localparam int POS_W             = 4;
  localparam int STATUS_W          = 3;
  localparam int LEN_OUT_W         = 5;
  localparam int MAX_PER_CHAIN_DEF = 16;
  localparam int NUM_CHAINS_DEF    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_READ       = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_HOOK  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
  } entry_t;

  // sequencer -> walk unit
  typedef struct packed {
    logic clear;   // start of a request
    logic step;    // read data of one entry is present
    logic insert;  // register walk (else unregister walk)
    logic tail;    // final write of an insert
  } walk_ctl_t;

  // walk unit -> sequencer
  typedef struct packed {
    logic wr_en;
    logic wr_prev;  // write goes one slot below the entry just read
    logic hit;      // insert point or matching id seen
  } walk_res_t;

endpackage

// ===== hw/rtl/potc_if.sv =====
// Request and response channel interfaces.
interface potc_req_if;
  import potc_pkg::*;

  logic                valid;
  logic                ready;
  cmd_e                command;
  logic [HOOK_W-1:0]   hook;
  logic [ID_BITS-1:0]  entry_id;
  logic [PRI_BITS-1:0] entry_priority;
  logic [POS_W-1:0]    position;

  modport source (output valid, command, hook, entry_id, entry_priority, position,
                  input ready);
  modport sink   (input valid, command, hook, entry_id, entry_priority, position,
                  output ready);
endinterface

interface potc_rsp_if;
  import potc_pkg::*;

  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [ID_BITS-1:0]   found_id;
  logic [PRI_BITS-1:0]  found_priority;
  logic [LEN_OUT_W-1:0] chain_length;

  modport source (output valid, status, found_id, found_priority, chain_length,
                  input ready);
  modport sink   (input valid, status, found_id, found_priority, chain_length,
                  output ready);
endinterface

// ===== hw/rtl/potc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module potc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 80
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/potc_walk.sv =====
// Walk unit: priority/id compare and carry register for insert and remove passes.
module potc_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  potc_pkg::walk_ctl_t ctl_i,
  input  potc_pkg::entry_t    key_i,
  input  potc_pkg::entry_t    rd_data_i,
  output potc_pkg::entry_t    wr_data_o,
  output potc_pkg::walk_res_t res_o
);
  import potc_pkg::*;

  logic   hit_q, hit_d;
  entry_t carry_q, carry_d;

  always_comb begin
    hit_d       = hit_q;
    carry_d     = carry_q;
    res_o       = '0;
    wr_data_o   = carry_q;
    if (ctl_i.step) begin
      if (ctl_i.insert) begin
        if (hit_q) begin
          // ripple: drop the carried entry here, pick up the one read
          res_o.wr_en = 1'b1;
          wr_data_o   = carry_q;
          carry_d     = rd_data_i;
        end else if (key_i.pri > rd_data_i.pri) begin
          res_o.wr_en = 1'b1;
          wr_data_o   = key_i;
          carry_d     = rd_data_i;
          hit_d       = 1'b1;
        end
      end else begin
        if (hit_q) begin
          // close the gap: move entry one slot up the list
          res_o.wr_en   = 1'b1;
          res_o.wr_prev = 1'b1;
          wr_data_o     = rd_data_i;
        end else if (key_i.id == rd_data_i.id) begin
          hit_d = 1'b1;
        end
      end
    end
    if (ctl_i.tail) begin
      res_o.wr_en = 1'b1;
      wr_data_o   = hit_q ? carry_q : key_i;
    end
    if (ctl_i.clear) begin
      hit_d = 1'b0;
    end
    res_o.hit = hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

endmodule

// ===== hw/rtl/priority_ordered_chain_table.sv =====
// Flow: a bad hook, full chain, no-op or read past length goes from S_IDLE straight to
//   S_RESP; a read passes through S_READ; a walk in S_WALK reads one entry per cycle
//   through the single RAM read port, then a register writes its last slot in S_TAIL
//   before S_RESP. The response register loads in S_RESP once the output is free.
// Throughput: one request in flight; the next is taken once the response is registered.
// Reset: chain lengths clear to zero at once; the entry RAM is not cleared and needs no pass.
module priority_ordered_chain_table #(
  parameter int MAX_PER_CHAIN = potc_pkg::MAX_PER_CHAIN_DEF,
  parameter int NUM_CHAINS    = potc_pkg::NUM_CHAINS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  potc_req_if.sink   req_i,
  potc_rsp_if.source rsp_o
);
  import potc_pkg::*;

  // length counter holds 0..MAX_PER_CHAIN
  localparam int LEN_W = $clog2(MAX_PER_CHAIN + 1);
  localparam int CH_W  = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
  localparam int DEPTH = NUM_CHAINS * MAX_PER_CHAIN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer state
  state_e           state_q, state_d;
  status_e          status_q, status_d;
  logic [LEN_W-1:0] clen_q, clen_d;   // length of the selected chain
  logic [LEN_W-1:0] idx_q, idx_d;     // next entry to read in a walk
  logic             pend_q, pend_d;   // RAM read data of entry idx_q-1 is present

  // Request fields captured at acceptance
  cmd_e             cmd_q;
  logic [CH_W-1:0]  ch_q;
  entry_t           key_q;
  logic [POS_W-1:0] pos_q;
  logic [AW-1:0]    base_q;           // first RAM row of the chain

  // Per-chain lengths, live in flops
  logic [LEN_W-1:0] lens_q [NUM_CHAINS];
  logic             lens_we;
  logic [LEN_W-1:0] lens_wval;

  // Response register
  logic                 rsp_valid_q;
  status_e              rsp_status_q;
  logic [ID_BITS-1:0]   rsp_id_q;
  logic [PRI_BITS-1:0]  rsp_pri_q;
  logic [LEN_OUT_W-1:0] rsp_len_q;
  logic                 rsp_load;

  // RAM and walk unit
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  entry_t           ram_wdata_w;
  walk_ctl_t        wctl;
  walk_res_t        wres;
  logic [LEN_W-1:0] wr_pos;

  // Decode of the incoming request
  logic             hook_ok;
  logic [CH_W-1:0]  in_ch;
  logic [LEN_W-1:0] in_len;
  logic             req_acc;

  assign hook_ok = 32'(req_i.hook) < 32'(NUM_CHAINS);
  assign in_ch   = CH_W'(req_i.hook);
  assign in_len  = hook_ok ? lens_q[in_ch] : '0;
  assign req_acc = req_i.valid && req_i.ready;

  assign req_i.ready = (state_q == S_IDLE);

  // Walk writes land on the entry just read, or one below it when closing a gap
  assign wr_pos = idx_q - (wres.wr_prev ? LEN_W'(2) : LEN_W'(1));

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    clen_d    = clen_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    lens_we   = 1'b0;
    lens_wval = clen_q;
    ram_we    = 1'b0;
    ram_waddr = base_q + AW'(wr_pos);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = base_q + AW'(idx_q);
    wctl      = '0;
    rsp_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          wctl.clear = 1'b1;
          idx_d      = '0;
          clen_d     = in_len;
          if (!hook_ok) begin
            status_d = ST_BAD_HOOK;
            state_d  = S_RESP;
          end else begin
            unique case (req_i.command)
              CMD_REGISTER: begin
                if (32'(in_len) >= 32'(MAX_PER_CHAIN)) begin
                  status_d = ST_FULL;
                  state_d  = S_RESP;
                end else begin
                  status_d = ST_OK;
                  state_d  = S_WALK;
                end
              end
              CMD_UNREGISTER: begin
                status_d = ST_OK;
                state_d  = S_WALK;
              end
              CMD_READ: begin
                if (32'(req_i.position) >= 32'(in_len)) begin
                  status_d = ST_BAD_POS;
                  state_d  = S_RESP;
                end else begin
                  status_d = ST_OK;
                  state_d  = S_READ;
                end
              end
              default: begin
                status_d = ST_OK;
                state_d  = S_RESP;
              end
            endcase
          end
        end
      end

      S_WALK: begin
        // one read issued and one read result handled per cycle
        ram_re      = idx_q < clen_q;
        wctl.step   = pend_q;
        wctl.insert = (cmd_q == CMD_REGISTER);
        ram_we      = wres.wr_en;
        ram_wdata   = ram_wdata_w;
        pend_d      = ram_re;
        if (ram_re) begin
          idx_d = idx_q + LEN_W'(1);
        end
        if (!ram_re && !pend_q) begin
          if (cmd_q == CMD_REGISTER) begin
            state_d = S_TAIL;
          end else begin
            if (wres.hit) begin
              clen_d    = clen_q - LEN_W'(1);
              lens_we   = 1'b1;
              lens_wval = clen_q - LEN_W'(1);
              status_d  = ST_OK;
            end else begin
              status_d  = ST_NOT_FOUND;
            end
            state_d = S_RESP;
          end
        end
      end

      S_TAIL: begin
        // last slot gets the carried entry, or the new one if it sorts last
        wctl.tail   = 1'b1;
        wctl.insert = 1'b1;
        ram_we      = 1'b1;
        ram_waddr   = base_q + AW'(clen_q);
        ram_wdata   = ram_wdata_w;
        clen_d      = clen_q + LEN_W'(1);
        lens_we     = 1'b1;
        lens_wval   = clen_q + LEN_W'(1);
        state_d     = S_RESP;
      end

      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = base_q + AW'(pos_q);
        state_d   = S_RESP;
      end

      S_RESP: begin
        // RAM read data holds here since no read is issued
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  potc_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (wctl),
    .key_i     (key_q),
    .rd_data_i (ram_rdata),
    .wr_data_o (ram_wdata_w),
    .res_o     (wres)
  );

  potc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      clen_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHAINS; i++) begin
        lens_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      clen_q      <= clen_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_o.ready);
      if (lens_we) begin
        lens_q[ch_q] <= lens_wval;
      end
    end
  end

  // Request capture and response payload
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q     <= req_i.command;
      ch_q      <= in_ch;
      key_q.id  <= req_i.entry_id;
      key_q.pri <= req_i.entry_priority;
      pos_q     <= req_i.position;
      base_q    <= AW'(32'(in_ch) * MAX_PER_CHAIN);
    end
    if (rsp_load) begin
      rsp_status_q <= status_q;
      // found fields only on a successful read
      if (cmd_q == CMD_READ && status_q == ST_OK) begin
        rsp_id_q  <= ram_rdata.id;
        rsp_pri_q <= ram_rdata.pri;
      end else begin
        rsp_id_q  <= '0;
        rsp_pri_q <= '0;
      end
      rsp_len_q <= LEN_OUT_W'(clen_q);
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_id       = rsp_id_q;
  assign rsp_o.found_priority = rsp_pri_q;
  assign rsp_o.chain_length   = rsp_len_q;

endmodule

// ===== hw/rtl/potc_chk.sv =====
// Port-level checker for the chain table, bound to the top level.
module potc_chk #(
  parameter int MAX_PER_CHAIN = potc_pkg::MAX_PER_CHAIN_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [potc_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [potc_pkg::ID_BITS-1:0]   rsp_found_id_i,
  input logic [potc_pkg::PRI_BITS-1:0]  rsp_found_priority_i,
  input logic [potc_pkg::LEN_OUT_W-1:0] rsp_chain_length_i
);
  import potc_pkg::*;

  // one request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // found fields are zero on every response whose status is not OK
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_found_id_i == '0 && rsp_found_priority_i == '0)
    else $error("found fields set on failed request");

  a_bad_hook_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_BAD_HOOK |-> rsp_chain_length_i == '0)
    else $error("chain length reported for bad hook");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_chain_length_i == LEN_OUT_W'(MAX_PER_CHAIN))
    else $error("full status with short chain");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_found_id_i) && $stable(rsp_chain_length_i))
    else $error("stalled response changed");

endmodule

bind priority_ordered_chain_table potc_chk #(
  .MAX_PER_CHAIN (MAX_PER_CHAIN)
) u_potc_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_status_i         (rsp_o.status),
  .rsp_found_id_i       (rsp_o.found_id),
  .rsp_found_priority_i (rsp_o.found_priority),
  .rsp_chain_length_i   (rsp_o.chain_length)
);

// ===== verif/potc_chain_checker.sv =====
// Watches both channels of the chain table, predicts each response and compares it.
module potc_chain_checker #(
  parameter int MAX_PER_CHAIN = potc_pkg::MAX_PER_CHAIN_DEF,
  parameter int NUM_CHAINS    = potc_pkg::NUM_CHAINS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  potc_req_if  req_i,
  potc_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import potc_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [ID_BITS-1:0]   found_id;
    logic [PRI_BITS-1:0]  found_priority;
    logic [LEN_OUT_W-1:0] chain_length;
  } rsp_rec_t;

  entry_t   chain_store [NUM_CHAINS][MAX_PER_CHAIN];
  int       chain_len   [NUM_CHAINS];
  rsp_rec_t pending_rsp_q[$];
  int       fail_total;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_total++;
  endtask

  // Applies one request to the shadow chains and returns the response it must give.
  function automatic rsp_rec_t apply_chain_request(input cmd_e                cmd,
                                                   input logic [HOOK_W-1:0]   hook,
                                                   input logic [ID_BITS-1:0]  id,
                                                   input logic [PRI_BITS-1:0] pri,
                                                   input logic [POS_W-1:0]    pos);
    rsp_rec_t r;
    int       ch;
    int       len;
    int       at;
    int       idx;
    r = '{status: ST_OK, found_id: '0, found_priority: '0, chain_length: '0};
    if (int'(hook) >= NUM_CHAINS) begin
      r.status = ST_BAD_HOOK;
    end else begin
      ch  = int'(hook);
      len = chain_len[ch];
      case (cmd)
        CMD_REGISTER: begin
          if (len >= MAX_PER_CHAIN) begin
            r.status = ST_FULL;
          end else begin
            // insert ahead of the first strictly lower priority
            at = len;
            for (idx = len - 1; idx >= 0; idx--)
              if (pri > chain_store[ch][idx].pri) at = idx;
            for (idx = len; idx > at; idx--)
              chain_store[ch][idx] = chain_store[ch][idx-1];
            chain_store[ch][at] = '{id: id, pri: pri};
            chain_len[ch] = len + 1;
          end
        end
        CMD_UNREGISTER: begin
          at = -1;
          for (idx = len - 1; idx >= 0; idx--)
            if (chain_store[ch][idx].id == id) at = idx;
          if (at < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (idx = at; idx + 1 < len; idx++)
              chain_store[ch][idx] = chain_store[ch][idx+1];
            chain_len[ch] = len - 1;
          end
        end
        CMD_READ: begin
          if (int'(pos) < len) begin
            r.found_id       = chain_store[ch][pos].id;
            r.found_priority = chain_store[ch][pos].pri;
          end else begin
            r.status = ST_BAD_POS;
          end
        end
        default: ;
      endcase
      r.chain_length = LEN_OUT_W'(chain_len[ch]);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_rec_t want;
    if (!rst_ni) begin
      foreach (chain_len[c]) chain_len[c] = 0;
      pending_rsp_q.delete();
      fail_total   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status: got %0d, expected %0d",
                                      rsp_i.status, want.status));
          if (rsp_i.found_id !== want.found_id)
            report_mismatch($sformatf("found_id: got %0d, expected %0d",
                                      rsp_i.found_id, want.found_id));
          if (rsp_i.found_priority !== want.found_priority)
            report_mismatch($sformatf("found_priority: got %0d, expected %0d",
                                      rsp_i.found_priority, want.found_priority));
          if (rsp_i.chain_length !== want.chain_length)
            report_mismatch($sformatf("chain_length: got %0d, expected %0d",
                                      rsp_i.chain_length, want.chain_length));
        end
      end
      if (req_i.valid && req_i.ready)
        pending_rsp_q.push_back(apply_chain_request(req_i.command, req_i.hook,
                                                    req_i.entry_id, req_i.entry_priority,
                                                    req_i.position));
      fail_count_o <= fail_total;
      pending_o    <= pending_rsp_q.size();
    end
  end

endmodule

// ===== verif/tb_priority_ordered_chain_table.sv =====
// Top of the chain table testbench: clock, reset, request stimulus, response stalls, verdict.
module tb_priority_ordered_chain_table;
  import potc_pkg::*;

  localparam int MAX_PER_CHAIN = MAX_PER_CHAIN_DEF;
  localparam int NUM_CHAINS    = NUM_CHAINS_DEF;

  // Chain selectors; anything from 5 up is an invalid hook.
  localparam logic [HOOK_W-1:0] HOOK_LOCAL_IN     = 3'd0;
  localparam logic [HOOK_W-1:0] HOOK_LOCAL_OUT    = 3'd1;
  localparam logic [HOOK_W-1:0] HOOK_FORWARD      = 3'd2;
  localparam logic [HOOK_W-1:0] HOOK_POST_ROUTING = 3'd3;
  localparam logic [HOOK_W-1:0] HOOK_PRE_ROUTING  = 3'd4;
  localparam logic [HOOK_W-1:0] HOOK_BAD_FIRST    = 3'd5;
  localparam logic [HOOK_W-1:0] HOOK_BAD_MID      = 3'd6;
  localparam logic [HOOK_W-1:0] HOOK_BAD_LAST     = 3'd7;

  localparam int RANDOM_REQUESTS = 925;
  // Give any stray response time to show up.
  localparam int SETTLE_CYCLES   = 60;
  // Longest quiet stretch in a good run: longest sender gap + full walk + longest receiver hold,
  // with back-to-back holds possible, so allow a wide margin.
  localparam int QUIET_LIMIT     = 4000;

  // Traffic mix of one random phase.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_MIXED
  } traffic_mix_e;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   quiet_cycles;
  bit   req_calm;   // no gaps between requests in this stretch
  bit   rsp_calm;   // no response back-pressure in this stretch
  int   hold_left;

  potc_req_if req_if ();
  potc_rsp_if rsp_if ();

  priority_ordered_chain_table #(
    .MAX_PER_CHAIN (MAX_PER_CHAIN),
    .NUM_CHAINS    (NUM_CHAINS)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  potc_chain_checker #(
    .MAX_PER_CHAIN (MAX_PER_CHAIN),
    .NUM_CHAINS    (NUM_CHAINS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  function automatic int unsigned pick_hold();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Drives one request and returns at the edge where it is taken.
  // valid stays high when the next request follows with no gap.
  task automatic send_request(input cmd_e                cmd,
                              input logic [HOOK_W-1:0]   hook,
                              input logic [ID_BITS-1:0]  id,
                              input logic [PRI_BITS-1:0] pri,
                              input logic [POS_W-1:0]    pos);
    int unsigned gap;
    gap = req_calm ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.command        <= cmd;
    req_if.hook           <= hook;
    req_if.entry_id       <= id;
    req_if.entry_priority <= pri;
    req_if.position       <= pos;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // One random request shaped by the phase mix. Most traffic hits the focus chain so
  // that it fills up and drains again; small ids make unregister hits and duplicates
  // common, and a few priority values repeat to exercise equal-priority ordering.
  task automatic send_random_request(input traffic_mix_e mix, input int focus);
    int unsigned         r;
    cmd_e                cmd;
    logic [HOOK_W-1:0]   hook;
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
    r = $urandom_range(0, 99);
    if (r < 8)       hook = HOOK_W'($urandom_range(HOOK_BAD_FIRST, HOOK_BAD_LAST));
    else if (r < 70) hook = HOOK_W'(focus);
    else             hook = HOOK_W'($urandom_range(HOOK_LOCAL_IN, HOOK_PRE_ROUTING));

    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  cmd = (r < 65) ? CMD_REGISTER : (r < 80) ? CMD_UNREGISTER :
                       (r < 97) ? CMD_READ : CMD_NOP;
      MIX_DRAIN: cmd = (r < 20) ? CMD_REGISTER : (r < 75) ? CMD_UNREGISTER :
                       (r < 97) ? CMD_READ : CMD_NOP;
      default:   cmd = (r < 35) ? CMD_REGISTER : (r < 65) ? CMD_UNREGISTER :
                       (r < 97) ? CMD_READ : CMD_NOP;
    endcase

    id = ($urandom_range(0, 99) < 70) ? ID_BITS'($urandom_range(0, 15))
                                      : ID_BITS'($urandom_range(0, 255));

    r = $urandom_range(0, 99);
    if (r < 10)      pri = '0;
    else if (r < 20) pri = '1;
    else if (r < 30) pri = PRI_BITS'(8'h80);
    else if (r < 40) pri = PRI_BITS'(8'h7f);
    else if (r < 60) pri = PRI_BITS'($urandom_range(100, 103));
    else             pri = PRI_BITS'($urandom_range(0, 255));

    send_request(cmd, hook, id, pri, POS_W'($urandom_range(0, 15)));
  endtask

  // Response side: ready drops at random, in short and occasional long holds,
  // independent of whether a response is waiting.
  initial begin
    rsp_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
        hold_left = pick_hold() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on quiet cycles: no request and no response taken.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] timeout: no traffic for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    traffic_mix_e mix;
    int           focus;
    int           sent;
    int           phase_len;

    req_if.valid          = 1'b0;
    req_if.command        = CMD_NOP;
    req_if.hook           = '0;
    req_if.entry_id       = '0;
    req_if.entry_priority = '0;
    req_if.position       = '0;
    req_calm              = 1'b0;
    rsp_calm              = 1'b1;
    sent                  = 0;
    rst_n                 = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // empty chain: read past length, unregister of an unknown id
    send_request(CMD_READ,       HOOK_LOCAL_IN, 8'h00, 8'h00, 4'd0);
    send_request(CMD_UNREGISTER, HOOK_LOCAL_IN, 8'h12, 8'h00, 4'd0);
    // invalid hooks, one per command, no state change
    send_request(CMD_REGISTER,   HOOK_BAD_LAST,  8'hff, 8'hff, 4'hf);
    send_request(CMD_UNREGISTER, HOOK_BAD_FIRST, 8'h00, 8'h00, 4'h0);
    send_request(CMD_READ,       HOOK_BAD_MID,   8'h5a, 8'ha5, 4'h5);
    send_request(CMD_NOP,        HOOK_BAD_LAST,  8'h00, 8'h00, 4'h0);
    // unused command on a valid hook
    send_request(CMD_NOP,        HOOK_FORWARD,   8'hff, 8'hff, 4'hf);
    // field extremes and ordering: min, max, two equal priorities, duplicate id
    send_request(CMD_REGISTER, HOOK_LOCAL_IN, 8'h00, 8'h00, 4'h0);
    send_request(CMD_REGISTER, HOOK_LOCAL_IN, 8'hff, 8'hff, 4'hf);
    send_request(CMD_REGISTER, HOOK_LOCAL_IN, 8'h55, 8'h80, 4'h0);
    send_request(CMD_REGISTER, HOOK_LOCAL_IN, 8'haa, 8'h80, 4'h0);
    send_request(CMD_REGISTER, HOOK_LOCAL_IN, 8'h55, 8'h10, 4'h0);
    for (int p = 0; p < 5; p++)
      send_request(CMD_READ, HOOK_LOCAL_IN, 8'h00, 8'h00, POS_W'(p));
    send_request(CMD_READ, HOOK_LOCAL_IN, 8'h00, 8'h00, 4'hf);
    // only the first of the duplicates goes
    send_request(CMD_UNREGISTER, HOOK_LOCAL_IN, 8'h55, 8'h00, 4'h0);
    send_request(CMD_READ,       HOOK_LOCAL_IN, 8'h00, 8'h00, 4'd1);
    send_request(CMD_READ,       HOOK_LOCAL_IN, 8'h00, 8'h00, 4'd3);
    // other chains are independent
    send_request(CMD_REGISTER, HOOK_PRE_ROUTING,  8'h01, 8'h7f, 4'h0);
    send_request(CMD_READ,     HOOK_PRE_ROUTING,  8'h00, 8'h00, 4'd0);
    send_request(CMD_READ,     HOOK_POST_ROUTING, 8'h00, 8'h00, 4'd0);
    send_request(CMD_REGISTER, HOOK_LOCAL_OUT,    8'h02, 8'h01, 4'h0);

    // ---- random part, in phases of differing mix, focus chain and idling ----
    while (sent < RANDOM_REQUESTS) begin
      mix       = traffic_mix_e'($urandom_range(MIX_FILL, MIX_MIXED));
      focus     = $urandom_range(HOOK_LOCAL_IN, HOOK_PRE_ROUTING);
      req_calm  = ($urandom_range(0, 3) == 0);
      rsp_calm  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
        send_random_request(mix, focus);
        sent++;
      end
    end
    req_if.valid <= 1'b0;
    rsp_calm = 1'b0;

    // let the last request show in the outstanding count before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    // anything still outstanding counts against the run
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== priority_ordered_chain_table.f =====
hw/rtl/potc_pkg.sv
hw/rtl/potc_if.sv
hw/rtl/potc_ram.sv
hw/rtl/potc_walk.sv
hw/rtl/priority_ordered_chain_table.sv
hw/rtl/potc_chk.sv
verif/potc_chain_checker.sv
verif/tb_priority_ordered_chain_table.sv
